[design/ustd_pkg.sv]
// ----------------------------------------------------------------------------
// ustd_pkg
// shared types, constants and byte helpers of the ustar stream deframer
// ----------------------------------------------------------------------------
package ustd_pkg;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_DATA    = 2'd1;
    localparam logic [1:0] KIND_PAD     = 2'd2;
    localparam logic [1:0] KIND_DISCARD = 2'd3;

    localparam logic [1:0] STAT_RUN  = 2'd0;
    localparam logic [1:0] STAT_DONE = 2'd1;
    localparam logic [1:0] STAT_ERR  = 2'd2;

    localparam logic [2:0] FAULT_NONE      = 3'd0;
    localparam logic [2:0] FAULT_TOO_LARGE = 3'd1;
    localparam logic [2:0] FAULT_MAGIC     = 3'd2;
    localparam logic [2:0] FAULT_CHECKSUM  = 3'd3;
    localparam logic [2:0] FAULT_NAME      = 3'd4;
    localparam logic [2:0] FAULT_TYPE      = 3'd5;
    localparam logic [2:0] FAULT_SIZE      = 3'd6;
    localparam logic [2:0] FAULT_COUNT     = 3'd7;

    localparam logic [1:0] REG_MAX_FILE_BYTES    = 2'd0;
    localparam logic [1:0] REG_MAX_FILE_COUNT    = 2'd1;
    localparam logic [1:0] REG_MAX_PACKAGE_BYTES = 2'd2;

    localparam logic [20:0] MAX_FILE_BYTES_RST    = 21'd524288;
    localparam logic [5:0]  MAX_FILE_COUNT_RST    = 6'd32;
    localparam logic [22:0] MAX_PACKAGE_BYTES_RST = 23'd2097152;

    localparam logic [8:0] POS_SIZE   = 9'd124;
    localparam logic [8:0] POS_CHK    = 9'd148;
    localparam logic [8:0] POS_TYPE   = 9'd156;
    localparam logic [8:0] POS_MAGIC  = 9'd257;
    localparam logic [8:0] POS_LAST   = 9'd511;
    localparam logic [6:0] NAME_FIELD = 7'd100;
    localparam logic [6:0] NAME_LIMIT = 7'd64;

    localparam logic [23:0] CHK_LIMIT  = 24'hFFFFFF;
    localparam logic [23:0] SIZE_LIMIT = 24'h1FFFFF;

    typedef struct packed {
        logic       new_package;
        logic [7:0] data;
        logic       is_zero;
        logic       is_sep;
        logic       is_octal;
        logic       name_ok;
    } item_t;

    typedef struct packed {
        logic        any;
        logic        done;
        logic        bad;
        logic        over;
        logic [23:0] val;
    } oct_t;

    function automatic logic name_char_ok(logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) ||
               (b >= 8'h30 && b <= 8'h39) || b == 8'h2e || b == 8'h5f || b == 8'h2d;
    endfunction

    function automatic logic [7:0] magic_char(logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h75;
            3'd1:    c = 8'h73;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h61;
            3'd4:    c = 8'h72;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic oct_t octal_step(item_t it, oct_t cur, logic [23:0] lim);
        oct_t        r;
        logic [26:0] v;
        r = cur;
        v = {cur.val, 3'b000} + 27'(it.data[2:0]);
        if (!(cur.done || cur.bad)) begin
            if (it.is_sep) begin
                if (cur.any) begin
                    r.done = 1'b1;
                end
            end else if (!it.is_octal) begin
                r.bad = 1'b1;
            end else begin
                r.any = 1'b1;
                if (!cur.over) begin
                    if (v > {3'b000, lim}) begin
                        r.over = 1'b1;
                        r.val  = lim;
                    end else begin
                        r.val = v[23:0];
                    end
                end
            end
        end
        return r;
    endfunction

endpackage

[design/ustd_front.sv]
// ----------------------------------------------------------------------------
// ustd_front
// classifies each incoming byte and holds it in a two-entry queue
// ----------------------------------------------------------------------------
module ustd_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_new_package,
    input  logic [7:0]      s_data_byte,
    output logic            q_valid,
    input  logic            q_pop,
    output ustd_pkg::item_t q_item
);

    ustd_pkg::item_t mem [2];
    ustd_pkg::item_t in_item;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       push;

    always_comb begin
        in_item.new_package = s_new_package;
        in_item.data        = s_data_byte;
        in_item.is_zero     = (s_data_byte == 8'h00);
        in_item.is_sep      = (s_data_byte == 8'h00) || (s_data_byte == 8'h20);
        in_item.is_octal    = (s_data_byte >= 8'h30) && (s_data_byte <= 8'h37);
        in_item.name_ok     = ustd_pkg::name_char_ok(s_data_byte);
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + 2'd1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

[design/ustd_back.sv]
// ----------------------------------------------------------------------------
// ustd_back
// header checks, member tracking and the result register
// ----------------------------------------------------------------------------
module ustd_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [1:0]      cfg_index,
    input  logic [22:0]     cfg_wr_data,
    input  logic            q_valid,
    output logic            q_pop,
    input  ustd_pkg::item_t q_item,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [1:0]      m_byte_kind,
    output logic [7:0]      m_byte_echo,
    output logic [8:0]      m_header_offset,
    output logic [5:0]      m_file_number,
    output logic            m_entry_opened,
    output logic [20:0]     m_entry_bytes,
    output logic            m_file_end,
    output logic [1:0]      m_run_status,
    output logic [2:0]      m_fault_code
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_DATA,
        PH_PAD,
        PH_DONE,
        PH_ERR
    } phase_t;

    logic [20:0] max_file_bytes_reg;
    logic [5:0]  max_file_count_reg;
    logic [22:0] max_package_bytes_reg;

    phase_t        phase_reg, phase_next;
    logic [8:0]    block_pos_reg, block_pos_next;
    logic          all_zero_reg, all_zero_next;
    logic [16:0]   sum_reg, sum_next;
    ustd_pkg::oct_t chk_reg, chk_next;
    ustd_pkg::oct_t size_reg, size_next;
    logic [6:0]    name_len_reg, name_len_next;
    logic          name_end_reg, name_end_next;
    logic          name_bad_reg, name_bad_next;
    logic          magic_good_reg, magic_good_next;
    logic          type_good_reg, type_good_next;
    logic          zero_seen_reg, zero_seen_next;
    logic [5:0]    member_reg, member_next;
    logic [20:0]   data_left_reg, data_left_next;
    logic [8:0]    pad_left_reg, pad_left_next;
    logic [22:0]   bytes_seen_reg, bytes_seen_next;
    logic [2:0]    fault_reg, fault_next;

    logic          m_valid_reg;
    logic [1:0]    kind_reg, kind_next;
    logic [7:0]    echo_reg;
    logic [8:0]    hoff_reg, hoff_next;
    logic [5:0]    fnum_reg;
    logic          opened_reg, opened_next;
    logic [20:0]   ebytes_reg, ebytes_next;
    logic          fend_reg, fend_next;
    logic [1:0]    status_reg, status_next;
    logic [2:0]    fcode_reg, fcode_next;

    assign q_pop = q_valid && (!m_valid_reg || m_ready);

    always_comb begin
        phase_t         ph;
        logic [8:0]     p;
        logic [2:0]     midx;
        logic [20:0]    sz;
        logic           fail;
        logic [2:0]     code;
        ustd_pkg::oct_t size_cur;
        ustd_pkg::oct_t chk_cur;

        ph              = q_item.new_package ? PH_HEADER : phase_reg;
        block_pos_next  = q_item.new_package ? 9'd0 : block_pos_reg;
        all_zero_next   = q_item.new_package ? 1'b1 : all_zero_reg;
        sum_next        = q_item.new_package ? 17'd0 : sum_reg;
        chk_cur         = q_item.new_package ? '0 : chk_reg;
        size_cur        = q_item.new_package ? '0 : size_reg;
        name_len_next   = q_item.new_package ? 7'd0 : name_len_reg;
        name_end_next   = q_item.new_package ? 1'b0 : name_end_reg;
        name_bad_next   = q_item.new_package ? 1'b0 : name_bad_reg;
        magic_good_next = q_item.new_package ? 1'b1 : magic_good_reg;
        type_good_next  = q_item.new_package ? 1'b0 : type_good_reg;
        zero_seen_next  = q_item.new_package ? 1'b0 : zero_seen_reg;
        member_next     = q_item.new_package ? 6'd0 : member_reg;
        data_left_next  = q_item.new_package ? 21'd0 : data_left_reg;
        pad_left_next   = q_item.new_package ? 9'd0 : pad_left_reg;
        bytes_seen_next = q_item.new_package ? 23'd0 : bytes_seen_reg;
        fault_next      = q_item.new_package ? ustd_pkg::FAULT_NONE : fault_reg;
        chk_next        = chk_cur;
        size_next       = size_cur;

        kind_next   = ustd_pkg::KIND_DISCARD;
        hoff_next   = 9'd0;
        opened_next = 1'b0;
        ebytes_next = 21'd0;
        fend_next   = 1'b0;
        p           = block_pos_next;
        midx        = 3'(p - ustd_pkg::POS_MAGIC);
        sz          = size_cur.val[20:0];
        fail        = 1'b0;
        code        = ustd_pkg::FAULT_NONE;

        // package byte budget
        if (ph != PH_ERR) begin
            if (bytes_seen_next != 23'h7FFFFF) begin
                bytes_seen_next = bytes_seen_next + 23'd1;
            end
            if (bytes_seen_next > max_package_bytes_reg) begin
                ph         = PH_ERR;
                fault_next = ustd_pkg::FAULT_TOO_LARGE;
            end
        end

        case (ph)
            PH_HEADER: begin
                kind_next = ustd_pkg::KIND_HEADER;
                hoff_next = p;
                if (!q_item.is_zero) begin
                    all_zero_next = 1'b0;
                end
                if (p >= ustd_pkg::POS_CHK && p < ustd_pkg::POS_TYPE) begin
                    sum_next = sum_next + 17'd32;
                    chk_next = ustd_pkg::octal_step(q_item, chk_cur, ustd_pkg::CHK_LIMIT);
                end else begin
                    sum_next = sum_next + 17'(q_item.data);
                end
                if (p >= ustd_pkg::POS_SIZE && p < ustd_pkg::POS_SIZE + 9'd12) begin
                    size_next = ustd_pkg::octal_step(q_item, size_cur,
                                                     ustd_pkg::SIZE_LIMIT);
                end
                if (p < 9'(ustd_pkg::NAME_FIELD) && !name_end_next) begin
                    if (q_item.is_zero) begin
                        name_end_next = 1'b1;
                    end else begin
                        if ((name_len_next == 7'd0 && q_item.data == 8'h2e) ||
                            !q_item.name_ok) begin
                            name_bad_next = 1'b1;
                        end
                        name_len_next = name_len_next + 7'd1;
                    end
                end
                if (p >= ustd_pkg::POS_MAGIC && p < ustd_pkg::POS_MAGIC + 9'd5 &&
                    q_item.data != ustd_pkg::magic_char(midx)) begin
                    magic_good_next = 1'b0;
                end
                if (p == ustd_pkg::POS_TYPE) begin
                    type_good_next = q_item.is_zero || (q_item.data == 8'h30);
                end

                if (p != ustd_pkg::POS_LAST) begin
                    block_pos_next = p + 9'd1;
                end else begin
                    if (all_zero_next) begin
                        if (zero_seen_next) begin
                            ph = PH_DONE;
                        end
                        zero_seen_next = 1'b1;
                    end else begin
                        zero_seen_next = 1'b0;
                        fail = 1'b1;
                        if (!magic_good_next) begin
                            code = ustd_pkg::FAULT_MAGIC;
                        end else if (!chk_next.any || chk_next.bad ||
                                     chk_next.val != {7'd0, sum_next}) begin
                            code = ustd_pkg::FAULT_CHECKSUM;
                        end else if (name_bad_next || name_len_next == 7'd0 ||
                                     name_len_next >= ustd_pkg::NAME_LIMIT) begin
                            code = ustd_pkg::FAULT_NAME;
                        end else if (!type_good_next) begin
                            code = ustd_pkg::FAULT_TYPE;
                        end else if (!size_next.any || size_next.bad || size_next.over ||
                                     size_next.val[20:0] > max_file_bytes_reg) begin
                            code = ustd_pkg::FAULT_SIZE;
                        end else if (member_next >= max_file_count_reg) begin
                            code = ustd_pkg::FAULT_COUNT;
                        end else begin
                            fail = 1'b0;
                        end
                        if (fail) begin
                            ph         = PH_ERR;
                            fault_next = code;
                        end else begin
                            sz             = size_next.val[20:0];
                            member_next    = member_next + 6'd1;
                            opened_next    = 1'b1;
                            ebytes_next    = sz;
                            data_left_next = sz;
                            pad_left_next  = ~sz[8:0] + 9'd1;
                            if (sz == 21'd0) begin
                                fend_next = 1'b1;
                                ph        = PH_HEADER;
                            end else begin
                                ph = PH_DATA;
                            end
                        end
                    end
                    block_pos_next  = 9'd0;
                    all_zero_next   = 1'b1;
                    sum_next        = 17'd0;
                    chk_next        = '0;
                    size_next       = '0;
                    name_len_next   = 7'd0;
                    name_end_next   = 1'b0;
                    name_bad_next   = 1'b0;
                    magic_good_next = 1'b1;
                    type_good_next  = 1'b0;
                end
            end
            PH_DATA: begin
                kind_next = ustd_pkg::KIND_DATA;
                if (data_left_next != 21'd0) begin
                    data_left_next = data_left_next - 21'd1;
                end
                if (data_left_next == 21'd0) begin
                    fend_next = 1'b1;
                    ph = (pad_left_next != 9'd0) ? PH_PAD : PH_HEADER;
                end
            end
            PH_PAD: begin
                kind_next = ustd_pkg::KIND_PAD;
                if (pad_left_next != 9'd0) begin
                    pad_left_next = pad_left_next - 9'd1;
                end
                if (pad_left_next == 9'd0) begin
                    ph = PH_HEADER;
                end
            end
            default: begin
                kind_next = ustd_pkg::KIND_DISCARD;
            end
        endcase

        phase_next  = ph;
        status_next = (ph == PH_ERR)  ? ustd_pkg::STAT_ERR :
                      (ph == PH_DONE) ? ustd_pkg::STAT_DONE : ustd_pkg::STAT_RUN;
        fcode_next  = (ph == PH_ERR) ? fault_next : ustd_pkg::FAULT_NONE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_file_bytes_reg    <= ustd_pkg::MAX_FILE_BYTES_RST;
            max_file_count_reg    <= ustd_pkg::MAX_FILE_COUNT_RST;
            max_package_bytes_reg <= ustd_pkg::MAX_PACKAGE_BYTES_RST;
            phase_reg      <= PH_HEADER;
            block_pos_reg  <= 9'd0;
            all_zero_reg   <= 1'b1;
            sum_reg        <= 17'd0;
            chk_reg        <= '0;
            size_reg       <= '0;
            name_len_reg   <= 7'd0;
            name_end_reg   <= 1'b0;
            name_bad_reg   <= 1'b0;
            magic_good_reg <= 1'b1;
            type_good_reg  <= 1'b0;
            zero_seen_reg  <= 1'b0;
            member_reg     <= 6'd0;
            data_left_reg  <= 21'd0;
            pad_left_reg   <= 9'd0;
            bytes_seen_reg <= 23'd0;
            fault_reg      <= ustd_pkg::FAULT_NONE;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    ustd_pkg::REG_MAX_FILE_BYTES:    max_file_bytes_reg <= cfg_wr_data[20:0];
                    ustd_pkg::REG_MAX_FILE_COUNT:    max_file_count_reg <= cfg_wr_data[5:0];
                    ustd_pkg::REG_MAX_PACKAGE_BYTES: max_package_bytes_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (q_pop) begin
                phase_reg      <= phase_next;
                block_pos_reg  <= block_pos_next;
                all_zero_reg   <= all_zero_next;
                sum_reg        <= sum_next;
                chk_reg        <= chk_next;
                size_reg       <= size_next;
                name_len_reg   <= name_len_next;
                name_end_reg   <= name_end_next;
                name_bad_reg   <= name_bad_next;
                magic_good_reg <= magic_good_next;
                type_good_reg  <= type_good_next;
                zero_seen_reg  <= zero_seen_next;
                member_reg     <= member_next;
                data_left_reg  <= data_left_next;
                pad_left_reg   <= pad_left_next;
                bytes_seen_reg <= bytes_seen_next;
                fault_reg      <= fault_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            kind_reg   <= kind_next;
            echo_reg   <= q_item.data;
            hoff_reg   <= hoff_next;
            fnum_reg   <= member_next;
            opened_reg <= opened_next;
            ebytes_reg <= ebytes_next;
            fend_reg   <= fend_next;
            status_reg <= status_next;
            fcode_reg  <= fcode_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_byte_kind     = kind_reg;
    assign m_byte_echo     = echo_reg;
    assign m_header_offset = hoff_reg;
    assign m_file_number   = fnum_reg;
    assign m_entry_opened  = opened_reg;
    assign m_entry_bytes   = ebytes_reg;
    assign m_file_end      = fend_reg;
    assign m_run_status    = status_reg;
    assign m_fault_code    = fcode_reg;

endmodule

[design/ustar_stream_deframer_core.sv]
// ----------------------------------------------------------------------------
// ustar_stream_deframer_core
// streaming ustar archive parser, one byte per transfer
// ----------------------------------------------------------------------------
// Takes one archive byte per clock while s_ready is high and returns one tagged
// result per byte. A byte is first written into the two-entry front queue and is
// then parsed into the result register when the queue pops it. A byte leaves the
// queue when the result register is empty or its result is taken in the same
// cycle, so while a result waits the queue absorbs up to two more bytes before
// s_ready drops. The sustained rate is one byte per cycle while m_ready stays
// high, as the header check and member tracking in the back stage are
// combinational. The user must write limits through the cfg port only while
// no byte is in flight; the block itself does not enforce it.
module ustar_stream_deframer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [22:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_new_package,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_byte_kind,
    output logic [7:0]  m_byte_echo,
    output logic [8:0]  m_header_offset,
    output logic [5:0]  m_file_number,
    output logic        m_entry_opened,
    output logic [20:0] m_entry_bytes,
    output logic        m_file_end,
    output logic [1:0]  m_run_status,
    output logic [2:0]  m_fault_code
);

    logic            q_valid;
    logic            q_pop;
    ustd_pkg::item_t q_item;

    ustd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_new_package (s_new_package),
        .s_data_byte   (s_data_byte),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_item        (q_item)
    );

    ustd_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .q_valid         (q_valid),
        .q_pop           (q_pop),
        .q_item          (q_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_byte_kind     (m_byte_kind),
        .m_byte_echo     (m_byte_echo),
        .m_header_offset (m_header_offset),
        .m_file_number   (m_file_number),
        .m_entry_opened  (m_entry_opened),
        .m_entry_bytes   (m_entry_bytes),
        .m_file_end      (m_file_end),
        .m_run_status    (m_run_status),
        .m_fault_code    (m_fault_code)
    );

    a_fault_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_run_status == ustd_pkg::STAT_ERR |-> m_fault_code != ustd_pkg::FAULT_NONE)
        else $error("error result without fault code");

    a_open_in_header: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_entry_opened |->
            m_byte_kind == ustd_pkg::KIND_HEADER && m_run_status == ustd_pkg::STAT_RUN)
        else $error("entry opened outside a running header");

    a_offset_header_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_kind != ustd_pkg::KIND_HEADER |-> m_header_offset == 9'd0)
        else $error("header offset on non-header byte");

endmodule

[tb/ustar_stream_checker.sv]
// ----------------------------------------------------------------------------
// ustar_stream_checker
// watches both channels and the cfg port of the deframer, predicts the tag
// of every byte from its own model of the parser state and compares each
// result transfer field by field against the oldest prediction
// ----------------------------------------------------------------------------
module ustar_stream_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [22:0] cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_new_package,
    input  logic [7:0]  s_data_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_byte_kind,
    input  logic [7:0]  m_byte_echo,
    input  logic [8:0]  m_header_offset,
    input  logic [5:0]  m_file_number,
    input  logic        m_entry_opened,
    input  logic [20:0] m_entry_bytes,
    input  logic        m_file_end,
    input  logic [1:0]  m_run_status,
    input  logic [2:0]  m_fault_code,
    output int          fail_count,
    output int          pending
);

    typedef enum logic [2:0] {
        PS_HEADER = 3'd0,
        PS_DATA   = 3'd1,
        PS_PAD    = 3'd2,
        PS_DONE   = 3'd3,
        PS_ERR    = 3'd4
    } parse_state_t;

    localparam logic [3:0] OCT_ANY  = 4'b0001;
    localparam logic [3:0] OCT_DONE = 4'b0010;
    localparam logic [3:0] OCT_BAD  = 4'b0100;
    localparam logic [3:0] OCT_OVER = 4'b1000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  echo;
        logic [8:0]  hoff;
        logic [5:0]  fnum;
        logic        opened;
        logic [20:0] ebytes;
        logic        fend;
        logic [1:0]  stat;
        logic [2:0]  fault;
    } byte_tag_t;

    byte_tag_t tag_q[$];

    logic [20:0]  lim_file_bytes;
    logic [5:0]   lim_file_count;
    logic [22:0]  lim_package_bytes;

    parse_state_t pstate;
    logic [8:0]   pos;
    logic         all_zero;
    logic [16:0]  hsum;
    logic [23:0]  chk_val;
    logic [3:0]   chk_flg;
    logic [23:0]  size_val;
    logic [3:0]   size_flg;
    logic [6:0]   name_len;
    logic         name_end;
    logic         name_bad;
    logic         magic_ok;
    logic         type_ok;
    logic         zero_seen;
    logic [5:0]   members;
    logic [20:0]  data_cnt;
    logic [8:0]   pad_cnt;
    logic [22:0]  total_bytes;
    logic [2:0]   fault_reg;

    task automatic clear_header();
        pos = '0; all_zero = 1'b1; hsum = '0;
        chk_val = '0; chk_flg = '0; size_val = '0; size_flg = '0;
        name_len = '0; name_end = 1'b0; name_bad = 1'b0;
        magic_ok = 1'b1; type_ok = 1'b0;
    endtask

    task automatic clear_all();
        clear_header();
        pstate = PS_HEADER; zero_seen = 1'b0; members = '0;
        data_cnt = '0; pad_cnt = '0; total_bytes = '0; fault_reg = ustd_pkg::FAULT_NONE;
    endtask

    task automatic raise_fault(input logic [2:0] code);
        if (pstate != PS_ERR) begin
            pstate = PS_ERR;
            fault_reg = code;
        end
    endtask

    task automatic octal_digit(input logic [7:0] b, inout logic [23:0] val,
                               inout logic [3:0] flg, input logic [23:0] lim);
        logic [26:0] v;
        v = {val, 3'b000} + 27'(b[2:0]);
        if ((flg & (OCT_DONE | OCT_BAD)) == '0) begin
            if (b == 8'h00 || b == 8'h20) begin
                if (flg & OCT_ANY) flg = flg | OCT_DONE;
            end else if (b < 8'h30 || b > 8'h37) begin
                flg = flg | OCT_BAD;
            end else begin
                flg = flg | OCT_ANY;
                if ((flg & OCT_OVER) == '0) begin
                    if (v > {3'b000, lim}) begin
                        flg = flg | OCT_OVER;
                        val = lim;
                    end else begin
                        val = v[23:0];
                    end
                end
            end
        end
    endtask

    function automatic logic safe_char(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
               (b >= "0" && b <= "9") || b == "." || b == "_" || b == "-";
    endfunction

    task automatic tag_byte(input logic np, input logic [7:0] b, output byte_tag_t t);
        logic [20:0] sz;
        logic [7:0]  mchar;
        t = '0;
        t.kind = ustd_pkg::KIND_DISCARD;
        t.echo = b;
        if (np) clear_all();
        if (pstate != PS_ERR) begin
            if (total_bytes != 23'h7FFFFF) total_bytes = total_bytes + 1'b1;
            if (total_bytes > lim_package_bytes) raise_fault(ustd_pkg::FAULT_TOO_LARGE);
        end
        case (pstate)
            PS_HEADER: begin
                t.kind = ustd_pkg::KIND_HEADER;
                t.hoff = pos;
                if (b != 8'h00) all_zero = 1'b0;
                hsum = hsum + ((pos >= ustd_pkg::POS_CHK && pos < ustd_pkg::POS_CHK + 8) ?
                               17'd32 : 17'(b));
                if (pos >= ustd_pkg::POS_CHK && pos < ustd_pkg::POS_CHK + 8)
                    octal_digit(b, chk_val, chk_flg, 24'hFFFFFF);
                if (pos >= ustd_pkg::POS_SIZE && pos < ustd_pkg::POS_SIZE + 12)
                    octal_digit(b, size_val, size_flg, 24'h1FFFFF);
                if (pos < 100 && !name_end) begin
                    if (b == 8'h00) begin
                        name_end = 1'b1;
                    end else begin
                        if ((name_len == 0 && b == ".") || !safe_char(b)) name_bad = 1'b1;
                        name_len = name_len + 1'b1;
                    end
                end
                if (pos >= ustd_pkg::POS_MAGIC && pos < ustd_pkg::POS_MAGIC + 5) begin
                    case (pos - ustd_pkg::POS_MAGIC)
                        0: mchar = "u";
                        1: mchar = "s";
                        2: mchar = "t";
                        3: mchar = "a";
                        default: mchar = "r";
                    endcase
                    if (b != mchar) magic_ok = 1'b0;
                end
                if (pos == ustd_pkg::POS_TYPE) type_ok = (b == 8'h00 || b == "0");
                if (pos != ustd_pkg::POS_LAST) begin
                    pos = pos + 1'b1;
                end else if (all_zero) begin
                    if (zero_seen) pstate = PS_DONE;
                    zero_seen = 1'b1;
                    clear_header();
                end else begin
                    zero_seen = 1'b0;
                    if (!magic_ok) raise_fault(ustd_pkg::FAULT_MAGIC);
                    else if ((chk_flg & (OCT_ANY | OCT_BAD)) != OCT_ANY ||
                             chk_val != {7'd0, hsum}) raise_fault(ustd_pkg::FAULT_CHECKSUM);
                    else if (name_bad || name_len == 0 || name_len >= 64)
                        raise_fault(ustd_pkg::FAULT_NAME);
                    else if (!type_ok) raise_fault(ustd_pkg::FAULT_TYPE);
                    else if ((size_flg & (OCT_ANY | OCT_BAD | OCT_OVER)) != OCT_ANY ||
                             size_val > {3'd0, lim_file_bytes})
                        raise_fault(ustd_pkg::FAULT_SIZE);
                    else if (members >= lim_file_count) raise_fault(ustd_pkg::FAULT_COUNT);
                    else begin
                        sz = size_val[20:0];
                        members = members + 1'b1;
                        t.opened = 1'b1;
                        t.ebytes = sz;
                        data_cnt = sz;
                        pad_cnt = 9'(-sz);
                        if (sz == 0) begin
                            t.fend = 1'b1;
                            pstate = (pad_cnt != 0) ? PS_PAD : PS_HEADER;
                        end else begin
                            pstate = PS_DATA;
                        end
                    end
                    clear_header();
                end
            end
            PS_DATA: begin
                t.kind = ustd_pkg::KIND_DATA;
                if (data_cnt != 0) data_cnt = data_cnt - 1'b1;
                if (data_cnt == 0) begin
                    t.fend = 1'b1;
                    pstate = (pad_cnt != 0) ? PS_PAD : PS_HEADER;
                end
            end
            PS_PAD: begin
                t.kind = ustd_pkg::KIND_PAD;
                if (pad_cnt != 0) pad_cnt = pad_cnt - 1'b1;
                if (pad_cnt == 0) pstate = PS_HEADER;
            end
            default: ;
        endcase
        t.stat = (pstate == PS_ERR) ? ustd_pkg::STAT_ERR :
                 (pstate == PS_DONE) ? ustd_pkg::STAT_DONE : ustd_pkg::STAT_RUN;
        t.fnum = members;
        t.fault = (pstate == PS_ERR) ? fault_reg : ustd_pkg::FAULT_NONE;
    endtask

    task automatic cmp_field(input string fname, input int unsigned exp_v,
                             input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, exp_v, act_v);
            fail_count++;
        end
    endtask

    // signals are driven at the rising edge, so the falling edge sees what
    // the next rising edge will commit
    always @(negedge aclk) begin
        byte_tag_t t;
        byte_tag_t e;
        if (!aresetn) begin
            fail_count = 0;
            lim_file_bytes = ustd_pkg::MAX_FILE_BYTES_RST;
            lim_file_count = ustd_pkg::MAX_FILE_COUNT_RST;
            lim_package_bytes = ustd_pkg::MAX_PACKAGE_BYTES_RST;
            clear_all();
            tag_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    ustd_pkg::REG_MAX_FILE_BYTES:    lim_file_bytes = cfg_wr_data[20:0];
                    ustd_pkg::REG_MAX_FILE_COUNT:    lim_file_count = cfg_wr_data[5:0];
                    ustd_pkg::REG_MAX_PACKAGE_BYTES: lim_package_bytes = cfg_wr_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                tag_byte(s_new_package, s_data_byte, t);
                tag_q.push_back(t);
            end
            if (m_valid && m_ready) begin
                if (tag_q.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none, actual kind %0d",
                             $time, m_byte_kind);
                    fail_count++;
                end else begin
                    e = tag_q.pop_front();
                    cmp_field("byte_kind", e.kind, m_byte_kind);
                    cmp_field("byte_echo", e.echo, m_byte_echo);
                    cmp_field("header_offset", e.hoff, m_header_offset);
                    cmp_field("file_number", e.fnum, m_file_number);
                    cmp_field("entry_opened", e.opened, m_entry_opened);
                    cmp_field("entry_bytes", e.ebytes, m_entry_bytes);
                    cmp_field("file_end", e.fend, m_file_end);
                    cmp_field("run_status", e.stat, m_run_status);
                    cmp_field("fault_code", e.fault, m_fault_code);
                end
            end
        end
        pending = tag_q.size();
    end

endmodule

[tb/tb_ustar_stream_deframer_core.sv]
// ----------------------------------------------------------------------------
// tb_ustar_stream_deframer_core
// stimulus and verdict for the ustar stream deframer
// ----------------------------------------------------------------------------
// Streams short noise, one archive member built on the fly (good or broken in
// one checked way) with its data, an end-of-archive pair of zero blocks and
// bytes past the end, then runs the byte budget out under small limits,
// with random idling on both channels but during the end blocks. A separate
// checker predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module tb_ustar_stream_deframer_core;

    localparam int WATCHDOG_LIMIT = 4000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = ustd_pkg::REG_MAX_FILE_BYTES;
    logic [22:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_new_package = 1'b0;
    logic [7:0]  s_data_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_byte_kind;
    logic [7:0]  m_byte_echo;
    logic [8:0]  m_header_offset;
    logic [5:0]  m_file_number;
    logic        m_entry_opened;
    logic [20:0] m_entry_bytes;
    logic        m_file_end;
    logic [1:0]  m_run_status;
    logic [2:0]  m_fault_code;

    int          fail_count;
    int          pending;
    bit          idle_en = 1'b1;
    int          quiet_cycles = 0;
    logic [7:0]  hdr [512];
    int          file_limit = ustd_pkg::MAX_FILE_BYTES_RST;

    always #5 aclk = ~aclk;

    ustar_stream_deframer_core i_dut (.*);

    ustar_stream_checker i_checker (.*);

    always @(posedge aclk) begin
        m_ready <= !idle_en || ($urandom_range(99) >= 37);
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic put_byte(input logic np, input logic [7:0] b);
        bit ok;
        while (idle_en && $urandom_range(99) < 37) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_new_package <= np;
        s_data_byte <= b;
        forever begin
            @(negedge aclk);
            ok = s_ready;
            @(posedge aclk);
            if (ok) break;
        end
    endtask

    task automatic write_limits(input int fbytes, input int fcount, input int pbytes);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= ustd_pkg::REG_MAX_FILE_BYTES;
        cfg_wr_data <= 23'(fbytes);
        @(posedge aclk);
        cfg_index <= ustd_pkg::REG_MAX_FILE_COUNT;
        cfg_wr_data <= 23'(fcount);
        @(posedge aclk);
        cfg_index <= ustd_pkg::REG_MAX_PACKAGE_BYTES;
        cfg_wr_data <= 23'(pbytes);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        file_limit = fbytes;
    endtask

    function automatic logic [7:0] name_char();
        string pool;
        pool = "abcdefghijklmnopqrstuvwxyzABCDEFXYZ0123456789._-";
        return pool[$urandom_range(pool.len() - 1)];
    endfunction

    // mode 0 builds a well-formed header, modes 1 to 6 break one check, mode 7 overwrites one random byte
    task automatic build_header(input int sz, input int mode);
        int unsigned hsum;
        int          nlen;
        int          first;
        for (int i = 0; i < 512; i++) hdr[i] = 8'h00;
        nlen = $urandom_range(1, 12);
        for (int i = 0; i < nlen; i++) hdr[i] = name_char();
        if (hdr[0] == ".") hdr[0] = "f";
        first = ($urandom_range(3) == 0) ? 1 : 0;
        if (first == 1) hdr[ustd_pkg::POS_SIZE] = " ";
        for (int i = first; i < 11; i++)
            hdr[ustd_pkg::POS_SIZE + i] = "0" + 8'((sz >> (3 * (10 - i))) & 7);
        hdr[ustd_pkg::POS_TYPE] = $urandom_range(1) ? "0" : 8'h00;
        hdr[ustd_pkg::POS_MAGIC + 0] = "u";
        hdr[ustd_pkg::POS_MAGIC + 1] = "s";
        hdr[ustd_pkg::POS_MAGIC + 2] = "t";
        hdr[ustd_pkg::POS_MAGIC + 3] = "a";
        hdr[ustd_pkg::POS_MAGIC + 4] = "r";
        hdr[263] = "0";
        hdr[264] = "0";
        case (mode)
            1: hdr[ustd_pkg::POS_MAGIC + $urandom_range(4)] = 8'($urandom_range(255));
            3: begin
                case ($urandom_range(3))
                    0: hdr[0] = ".";
                    1: hdr[$urandom_range(nlen - 1)] = "/";
                    2: hdr[0] = 8'h00;
                    default: for (int i = 0; i < 64; i++) hdr[i] = name_char();
                endcase
            end
            4: hdr[ustd_pkg::POS_TYPE] = "5";
            5: hdr[ustd_pkg::POS_SIZE + $urandom_range(10)] = "9";
            6: for (int i = 0; i < 11; i++) hdr[ustd_pkg::POS_SIZE + i] = "7";
            7: hdr[$urandom_range(511)] = 8'($urandom_range(255));
            default: ;
        endcase
        hsum = 8 * 32;
        for (int i = 0; i < 512; i++)
            if (i < ustd_pkg::POS_CHK || i >= ustd_pkg::POS_CHK + 8) hsum += hdr[i];
        for (int i = 0; i < 6; i++)
            hdr[ustd_pkg::POS_CHK + i] = "0" + 8'((hsum >> (3 * (5 - i))) & 7);
        hdr[ustd_pkg::POS_CHK + 6] = 8'h00;
        hdr[ustd_pkg::POS_CHK + 7] = " ";
        if (mode == 2) begin
            if ($urandom_range(1)) begin
                hdr[ustd_pkg::POS_CHK + 5] = hdr[ustd_pkg::POS_CHK + 5] ^ 8'h01;
            end else begin
                hdr[ustd_pkg::POS_CHK + 2] = "x";
            end
        end
    endtask

    // one header, up to 40 data bytes and a few padding bytes
    task automatic send_member();
        int sz;
        int mode;
        int ndata;
        mode = ($urandom_range(99) < 75) ? 0 : $urandom_range(1, 7);
        case ($urandom_range(7))
            0:       sz = 0;
            1:       sz = file_limit + $urandom_range(0, 1);
            default: sz = $urandom_range(1, 40);
        endcase
        build_header(sz, mode);
        for (int i = 0; i < 512; i++) put_byte(i == 0, hdr[i]);
        ndata = (sz > 40) ? 40 : sz;
        for (int i = 0; i < ndata; i++) put_byte(1'b0, 8'($urandom_range(255)));
        for (int i = 0; i < 4; i++) put_byte(1'b0, 8'h00);
    endtask

    // two zero blocks end the archive, then a few discarded bytes
    task automatic send_end();
        for (int i = 0; i < 1024; i++) put_byte(i == 0, 8'h00);
        for (int i = 0; i < 4; i++) put_byte(1'b0, 8'($urandom_range(255)));
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // short noise, noise bytes with all bit values
        put_byte(1'b0, 8'hFF);
        put_byte(1'b1, 8'h00);
        put_byte(1'b0, 8'hA5);
        put_byte(1'b0, 8'h5A);
        put_byte(1'b1, 8'h80);
        put_byte(1'b0, 8'h01);

        send_member();

        idle_en = 1'b0;
        write_limits(1048576, 63, 4194304);
        send_end();
        idle_en = 1'b1;

        write_limits(0, 0, 1);
        for (int i = 0; i < 6; i++) put_byte(i == 0, 8'($urandom_range(255)));

        write_limits($urandom_range(0, 1048576), $urandom_range(0, 63),
                     $urandom_range(1, 40));
        for (int i = 0; i < 48; i++) put_byte(i == 0, 8'($urandom_range(255)));

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
